// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the robust estimator weight block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define REW_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Check that a condition never holds on a rising clock edge outside reset.
`define REW_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define REW_ASSERT(lbl, clk, rst_n, prop)
`define REW_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: hw/rtl/rew_pkg.sv
// Package with types, constants and the exponential table of the estimator weight block.
`default_nettype none

package rew_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int X_W          = 24;
    localparam int SIGMA_W      = 24;
    localparam int KIND_W       = 3;
    localparam int W_W          = 32;
    localparam int SQ_W         = 2 * X_W;
    localparam int D_W          = SQ_W + 2;
    localparam int NUM_W        = 64;
    localparam int Q_W          = 32;
    localparam int Q30_BITS     = 30;
    localparam int R_W          = Q30_BITS + 1;
    localparam int EXP_IDX_BITS = 8;
    localparam int EXP_ENTRIES  = 1 << EXP_IDX_BITS;
    // exp(-1)^n * 2^30 drops below 2^(30-FRAC_BITS) for n >= 12, so the
    // weight is zero from there on
    localparam int GAUSS_STEPS  = 12;
    localparam int CNT_W        = 4;
    localparam int TUKEY_W      = FRAC_BITS + 1;

    localparam logic [SIGMA_W-1:0] SIGMA_RESET = SIGMA_W'(1) << FRAC_BITS;
    localparam logic [W_W-1:0]     W_TWO       = W_W'(2) << FRAC_BITS;
    localparam logic [W_W-1:0]     W_MAX       = '1;
    localparam logic [NUM_W-1:0]   RECIP_NUM   = NUM_W'(1) << (2 * FRAC_BITS);
    localparam logic [NUM_W-1:0]   LORENTZ_NUM = NUM_W'(2) << (3 * FRAC_BITS);

    typedef enum logic [KIND_W-1:0] {
        KIND_L2,
        KIND_TRUNC_L2,
        KIND_L1,
        KIND_TRUNC_L1,
        KIND_HUBER,
        KIND_LORENTZ,
        KIND_GAUSS,
        KIND_TUKEY
    } kind_t;

    typedef enum logic [1:0] {
        SEL_FIXED,
        SEL_QUOT,
        SEL_TUKEY,
        SEL_GAUSS
    } sel_t;

    typedef logic [R_W-1:0] exp_tbl_t [EXP_ENTRIES];

    // Bitwise restoring division, used only to build constants.
    function automatic logic [63:0] const_div(logic [63:0] a, logic [63:0] b);
        logic [63:0] q;
        logic [63:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], a[i]};
            q   = {q[62:0], 1'b0};
            if (rem >= b)
            begin
                rem  = rem - b;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-t) in Q2.30 for t in Q2.30 within [0,1], by a truncated Taylor series.
    function automatic logic [63:0] exp_neg_q30(logic [63:0] t);
        logic [63:0] term;
        logic [63:0] sum;
        term = 64'd1 << Q30_BITS;
        sum  = term;
        for (int k = 1; k <= 24; k++)
        begin
            term = const_div((term * t) >> Q30_BITS, 64'(k));
            sum  = sum + term;
        end
        return const_div(64'd1 << (2 * Q30_BITS), sum);
    endfunction

    function automatic exp_tbl_t build_exp_tbl();
        exp_tbl_t tbl;
        for (int i = 0; i < EXP_ENTRIES; i++)
        begin
            tbl[i] = R_W'(exp_neg_q30(64'(i) << (Q30_BITS - EXP_IDX_BITS)));
        end
        return tbl;
    endfunction

    localparam exp_tbl_t       EXP_TBL = build_exp_tbl();
    localparam logic [R_W-1:0] EXP_E1  = R_W'(exp_neg_q30(64'd1 << Q30_BITS));

endpackage

`default_nettype wire

// File: hw/rtl/robust_estimator_weight.sv
// Top level of the robust estimator weight block: a deep pipeline with a shared divider.
//
// Usage:
//   Input channel (in_valid/in_ready, kind, residual) takes one residual and an
//   estimator selector per transaction. Output channel (out_valid/out_ready,
//   weight, saturated) returns one Q16.16 weight per input transaction, in order.
//   Config channel (cfg_valid/cfg_ready, cfg_data) writes sigma; it is always
//   ready. Write sigma only while no transaction is in flight.
// Pipeline: between an accepted input transaction and its result lie the
//   squaring, setup and divider-load stages, the 32-stage restoring
//   divider (one quotient bit per stage), one post stage and the 12-stage
//   Gaussian multiplier chain.
// Throughput: one transaction per cycle while the receiver keeps out_ready high.
// Stall: a two-entry output (last stage plus skid register) lets the pipeline
//   advance while a result waits; once the skid register fills, in_ready drops
//   and every stage holds until the receiver takes the waiting result.
// Reset: rst_n clears all valid bits and loads sigma with 1.0; no items survive.
`default_nettype none

`include "assert_macros.svh"

module robust_estimator_weight (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [rew_pkg::SIGMA_W-1:0]  cfg_data,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  [rew_pkg::KIND_W-1:0]   kind,
    input  wire  [rew_pkg::X_W-1:0]      residual,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [rew_pkg::W_W-1:0]      weight,
    output logic                         saturated
);

    localparam int DIV_STAGES = rew_pkg::Q_W;
    localparam int G_STEPS    = rew_pkg::GAUSS_STEPS;

    // stage A: squares
    typedef struct packed {
        logic                         vld;
        rew_pkg::kind_t               kind;
        logic [rew_pkg::X_W-1:0]      x;
        logic [rew_pkg::SIGMA_W-1:0]  s;
        logic [rew_pkg::SQ_W-1:0]     xx;
        logic [rew_pkg::SQ_W-1:0]     ss;
    } sa_t;

    // stage B: dividend, divisor and the fixed outcome
    typedef struct packed {
        logic                         vld;
        rew_pkg::sel_t                sel;
        logic [rew_pkg::NUM_W-1:0]    num;
        logic [rew_pkg::D_W-1:0]      den;
        logic [rew_pkg::W_W-1:0]      fix_w;
        logic                         fix_sat;
    } sb_t;

    // divider stages
    typedef struct packed {
        logic                         vld;
        rew_pkg::sel_t                sel;
        logic [rew_pkg::W_W-1:0]      fix_w;
        logic                         fix_sat;
        logic [rew_pkg::D_W-1:0]      den;
        logic [rew_pkg::D_W-1:0]      rem;
        logic [rew_pkg::Q_W-1:0]      nq;
    } dv_t;

    // post stages: weight or Gaussian product
    typedef struct packed {
        logic                         vld;
        logic                         gauss;
        logic [rew_pkg::W_W-1:0]      w;
        logic                         sat;
        logic [rew_pkg::R_W-1:0]      r;
        logic [rew_pkg::CNT_W-1:0]    cnt;
    } ps_t;

    logic [rew_pkg::SIGMA_W-1:0] sigma_reg;

    sa_t sa_reg, sa_next;
    sb_t sb_reg, sb_next;
    dv_t dv_reg  [DIV_STAGES+1];
    dv_t dv_next [DIV_STAGES+1];
    ps_t ps_reg  [G_STEPS+1];
    ps_t ps_next [G_STEPS+1];

    logic                    skid_vld_reg;
    logic [rew_pkg::W_W-1:0] skid_w_reg;
    logic                    skid_sat_reg;

    logic                    adv;
    logic [rew_pkg::W_W-1:0] fin_w;

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    function automatic dv_t div_step(dv_t d);
        dv_t                   o;
        logic [rew_pkg::D_W:0] part;
        logic [rew_pkg::D_W:0] diff;
        o    = d;
        part = {d.rem, d.nq[rew_pkg::Q_W-1]};
        diff = part - {1'b0, d.den};
        if (part >= {1'b0, d.den})
        begin
            o.rem = diff[rew_pkg::D_W-1:0];
            o.nq  = {d.nq[rew_pkg::Q_W-2:0], 1'b1};
        end
        else
        begin
            o.rem = part[rew_pkg::D_W-1:0];
            o.nq  = {d.nq[rew_pkg::Q_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // One factor of exp(-1) for each whole unit of u still pending.
    function automatic ps_t g_step(ps_t p, logic [rew_pkg::CNT_W-1:0] idx);
        ps_t                       o;
        logic [2*rew_pkg::R_W-1:0] prod;
        o    = p;
        prod = (2*rew_pkg::R_W)'(p.r) * (2*rew_pkg::R_W)'(rew_pkg::EXP_E1);
        if (p.gauss && (p.cnt > idx))
        begin
            o.r = rew_pkg::R_W'(prod >> rew_pkg::Q30_BITS);
        end
        return o;
    endfunction

    // Pipeline moves whenever the skid register is free.
    assign adv       = !skid_vld_reg;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg <= rew_pkg::SIGMA_RESET;
        end
        else if (cfg_valid)
        begin
            sigma_reg <= cfg_data;
        end
    end

    // Stage A: square residual and sigma.
    always_comb
    begin
        sa_next.vld  = in_valid;
        sa_next.kind = rew_pkg::kind_t'(kind);
        sa_next.x    = residual;
        sa_next.s    = sigma_reg;
        sa_next.xx   = rew_pkg::SQ_W'(residual) * rew_pkg::SQ_W'(residual);
        sa_next.ss   = rew_pkg::SQ_W'(sigma_reg) * rew_pkg::SQ_W'(sigma_reg);
    end

    // Stage B: map each estimator onto one quotient or a fixed result.
    always_comb
    begin
        logic                    x_lt_s;
        logic [rew_pkg::X_W-1:0] rdiv;
        x_lt_s = sa_reg.x < sa_reg.s;
        rdiv   = ((sa_reg.kind == rew_pkg::KIND_HUBER) && x_lt_s) ? sa_reg.s : sa_reg.x;

        sb_next.vld     = sa_reg.vld;
        sb_next.sel     = rew_pkg::SEL_FIXED;
        sb_next.num     = '0;
        sb_next.den     = '0;
        sb_next.fix_w   = '0;
        sb_next.fix_sat = 1'b0;

        case (sa_reg.kind)
            rew_pkg::KIND_L2:
            begin
                sb_next.fix_w = rew_pkg::W_TWO;
            end
            rew_pkg::KIND_TRUNC_L2:
            begin
                if (sa_reg.xx < rew_pkg::SQ_W'({sa_reg.s, rew_pkg::FRAC_BITS'(0)}))
                begin
                    sb_next.fix_w = rew_pkg::W_TWO;
                end
            end
            rew_pkg::KIND_L1, rew_pkg::KIND_HUBER:
            begin
                sb_next.sel = rew_pkg::SEL_QUOT;
                sb_next.num = rew_pkg::RECIP_NUM;
                sb_next.den = rew_pkg::D_W'(rdiv);
            end
            rew_pkg::KIND_TRUNC_L1:
            begin
                if (x_lt_s)
                begin
                    sb_next.sel = rew_pkg::SEL_QUOT;
                    sb_next.num = rew_pkg::RECIP_NUM;
                    sb_next.den = rew_pkg::D_W'(rdiv);
                end
            end
            rew_pkg::KIND_LORENTZ:
            begin
                sb_next.sel = rew_pkg::SEL_QUOT;
                sb_next.num = rew_pkg::LORENTZ_NUM;
                sb_next.den = rew_pkg::D_W'(sa_reg.xx) + (rew_pkg::D_W'(sa_reg.ss) << 1);
            end
            rew_pkg::KIND_GAUSS:
            begin
                if (sa_reg.s == '0)
                begin
                    sb_next.fix_sat = 1'b1;
                end
                else
                begin
                    sb_next.sel = rew_pkg::SEL_GAUSS;
                    sb_next.num = rew_pkg::NUM_W'(sa_reg.xx) << rew_pkg::EXP_IDX_BITS;
                    sb_next.den = rew_pkg::D_W'(sa_reg.ss);
                end
            end
            rew_pkg::KIND_TUKEY:
            begin
                if (x_lt_s)
                begin
                    sb_next.sel = rew_pkg::SEL_TUKEY;
                    sb_next.num = rew_pkg::NUM_W'(sa_reg.ss - sa_reg.xx) << rew_pkg::FRAC_BITS;
                    sb_next.den = rew_pkg::D_W'(sa_reg.ss);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Stage C: detect a quotient of 2^32 or more, load the divider; then the
    // divider steps.
    always_comb
    begin
        logic ovf;
        ovf = rew_pkg::D_W'(sb_reg.num[rew_pkg::NUM_W-1:rew_pkg::Q_W]) >= sb_reg.den;

        dv_next[0].vld     = sb_reg.vld;
        dv_next[0].sel     = sb_reg.sel;
        dv_next[0].fix_w   = sb_reg.fix_w;
        dv_next[0].fix_sat = sb_reg.fix_sat;
        dv_next[0].den     = sb_reg.den;
        dv_next[0].rem     = rew_pkg::D_W'(sb_reg.num[rew_pkg::NUM_W-1:rew_pkg::Q_W]);
        dv_next[0].nq      = sb_reg.num[rew_pkg::Q_W-1:0];

        if (ovf && (sb_reg.sel == rew_pkg::SEL_QUOT))
        begin
            // zero divisor or quotient too large: clip
            dv_next[0].sel     = rew_pkg::SEL_FIXED;
            dv_next[0].fix_w   = rew_pkg::W_MAX;
            dv_next[0].fix_sat = 1'b1;
        end
        else if (ovf && (sb_reg.sel == rew_pkg::SEL_GAUSS))
        begin
            dv_next[0].sel     = rew_pkg::SEL_FIXED;
            dv_next[0].fix_w   = '0;
            dv_next[0].fix_sat = 1'b0;
        end

        for (int i = 0; i < DIV_STAGES; i++)
        begin
            dv_next[i+1] = div_step(dv_reg[i]);
        end
    end

    // Post stage: pass a fixed result, pick quotient, square for Tukey, or start the
    // Gaussian product; then the Gaussian multiplier chain.
    always_comb
    begin
        logic [rew_pkg::Q_W-1:0]       q;
        logic [2*rew_pkg::TUKEY_W-1:0] tsq;
        q   = dv_reg[DIV_STAGES].nq;
        tsq = (2*rew_pkg::TUKEY_W)'(q[rew_pkg::TUKEY_W-1:0])
            * (2*rew_pkg::TUKEY_W)'(q[rew_pkg::TUKEY_W-1:0]);

        ps_next[0].vld   = dv_reg[DIV_STAGES].vld;
        ps_next[0].gauss = 1'b0;
        ps_next[0].w     = dv_reg[DIV_STAGES].fix_w;
        ps_next[0].sat   = dv_reg[DIV_STAGES].fix_sat;
        ps_next[0].r     = '0;
        ps_next[0].cnt   = '0;

        case (dv_reg[DIV_STAGES].sel)
            rew_pkg::SEL_QUOT:
            begin
                ps_next[0].w = q;
            end
            rew_pkg::SEL_TUKEY:
            begin
                ps_next[0].w = rew_pkg::W_W'(tsq >> (rew_pkg::FRAC_BITS + 1));
            end
            rew_pkg::SEL_GAUSS:
            begin
                ps_next[0].w = '0;
                if (q[rew_pkg::Q_W-1:rew_pkg::EXP_IDX_BITS]
                    < (rew_pkg::Q_W - rew_pkg::EXP_IDX_BITS)'(G_STEPS))
                begin
                    ps_next[0].gauss = 1'b1;
                    ps_next[0].cnt   = q[rew_pkg::EXP_IDX_BITS +: rew_pkg::CNT_W];
                    ps_next[0].r     = rew_pkg::EXP_TBL[q[rew_pkg::EXP_IDX_BITS-1:0]];
                end
            end
            default:
            begin
            end
        endcase

        for (int j = 0; j < G_STEPS; j++)
        begin
            ps_next[j+1] = g_step(ps_reg[j], rew_pkg::CNT_W'(j));
        end
    end

    // All stages: clear on reset, advance together, hold on stall.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_reg <= '0;
            sb_reg <= '0;
            for (int i = 0; i <= DIV_STAGES; i++)
            begin
                dv_reg[i] <= '0;
            end
            for (int j = 0; j <= G_STEPS; j++)
            begin
                ps_reg[j] <= '0;
            end
        end
        else if (adv)
        begin
            sa_reg <= sa_next;
            sb_reg <= sb_next;
            for (int i = 0; i <= DIV_STAGES; i++)
            begin
                dv_reg[i] <= dv_next[i];
            end
            for (int j = 0; j <= G_STEPS; j++)
            begin
                ps_reg[j] <= ps_next[j];
            end
        end
    end

    // Gaussian result leaves Q1.30 for the weight format.
    assign fin_w = ps_reg[G_STEPS].gauss
                 ? rew_pkg::W_W'(ps_reg[G_STEPS].r >> (rew_pkg::Q30_BITS - rew_pkg::FRAC_BITS))
                 : ps_reg[G_STEPS].w;

    // Skid register: catch the last stage when the receiver stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_vld_reg <= 1'b0;
        end
        else if (adv && ps_reg[G_STEPS].vld && !out_ready)
        begin
            skid_vld_reg <= 1'b1;
        end
        else if (skid_vld_reg && out_ready)
        begin
            skid_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            skid_w_reg   <= fin_w;
            skid_sat_reg <= ps_reg[G_STEPS].sat;
        end
    end

    assign out_valid = skid_vld_reg || ps_reg[G_STEPS].vld;
    assign weight    = skid_vld_reg ? skid_w_reg : fin_w;
    assign saturated = skid_vld_reg ? skid_sat_reg : ps_reg[G_STEPS].sat;

    `REW_ASSERT(a_skid_hold, clk, rst_n, skid_vld_reg && !out_ready |=> skid_vld_reg && $stable(skid_w_reg))
    `REW_ASSERT(a_skid_fill, clk, rst_n, $rose(skid_vld_reg) |-> !$past(out_ready))
    `REW_ASSERT(a_sat_value, clk, rst_n, out_valid && saturated |-> (weight == rew_pkg::W_MAX) || (weight == '0))
    `REW_ASSERT_NEVER(a_gauss_cnt, clk, rst_n, ps_reg[0].vld && ps_reg[0].gauss && (ps_reg[0].cnt >= rew_pkg::CNT_W'(G_STEPS)))

endmodule

`default_nettype wire
